FILE: rtl/core/slrr_pkg.sv
// Shared types and constants for the shape list row rasterizer.
`default_nettype none
package slrr_pkg;
   localparam int DEF_CANVAS_ROWS = 32;
   localparam int DEF_CANVAS_COLS = 64;
   localparam int DEF_SHAPE_SLOTS = 64;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_RENDER = 2'd2;

   localparam logic [1:0] KIND_RECT = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_TRI = 2'd2;
   localparam logic [1:0] KIND_CIRCLE = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD_ID = 2'd2;

   // Command handed from front to back.
   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] size_a;
      logic [15:0] size_b;
      logic [15:0] target_id;
      logic [4:0]  row_index;
   } cmd_type;

   // Result transaction.
   typedef struct packed {
      logic [6:0]  added_id;
      logic [63:0] row_bits;
      logic [1:0]  status;
   } rsp_type;
endpackage
`default_nettype wire

FILE: rtl/core/slrr_front.sv
// Front end: accepts request transactions into a short command queue.
`default_nettype none
module slrr_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  slrr_pkg::cmd_type     cmd_in,
   output logic                  cmd_valid,
   output slrr_pkg::cmd_type     cmd_out,
   input  wire                   cmd_take
);
   import slrr_pkg::*;

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       do_push, do_pop;

   assign full      = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_out   = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
      if (do_push) q_ff[wr_ff] <= cmd_in;
   end
endmodule
`default_nettype wire

FILE: rtl/core/slrr_back.sv
// Back end: display list store, row walk and result register.
`default_nettype none
module slrr_back #(
   parameter int CANVAS_ROWS = slrr_pkg::DEF_CANVAS_ROWS,
   parameter int CANVAS_COLS = slrr_pkg::DEF_CANVAS_COLS,
   parameter int SHAPE_SLOTS = slrr_pkg::DEF_SHAPE_SLOTS
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                cmd_valid,
   input  slrr_pkg::cmd_type  cmd,
   output logic               cmd_take,
   output logic               rsp_valid,
   output slrr_pkg::rsp_type  rsp,
   input  wire                rsp_pop
);
   import slrr_pkg::*;

   localparam int SW = (SHAPE_SLOTS > 1) ? $clog2(SHAPE_SLOTS) : 1;
   localparam int CW = $clog2(SHAPE_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SHAPE = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [SHAPE_SLOTS-1:0] active_ff, active_in;
   logic [CW-1:0]   walk_ff, walk_in;
   logic [4:0]      row_ff, row_in;
   logic [63:0]     acc_ff, acc_in;
   logic            rvalid_ff, rvalid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            line_ok_ff, line_ok_in;

   logic [65:0]     mem [SHAPE_SLOTS];
   logic [65:0]     rd_ff;
   logic            mem_we;
   logic [SW-1:0]   mem_wa, mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= {cmd.kind, cmd.size_b, cmd.size_a, cmd.pos_y, cmd.pos_x};
      rd_ff <= mem[mem_ra];
   end

   // Row mask of the shape held in rd_ff.
   logic signed [17:0] px, py, a, b, y, d;
   logic signed [17:0] lo, hi;
   logic               hit;
   logic [63:0]        span, circ;
   logic signed [23:0] dy20, r20;
   logic signed [47:0] lim;
   logic signed [24:0] dx11;
   logic signed [49:0] dx2;

   always_comb begin
      px = 18'(signed'(rd_ff[15:0]));
      py = 18'(signed'(rd_ff[31:16]));
      a  = 18'(signed'(rd_ff[47:32]));
      b  = 18'(signed'(rd_ff[63:48]));
      y  = 18'(signed'({1'b0, row_ff}));
      d  = y - py;
      hit = 1'b0;
      lo  = px;
      hi  = px + a;
      case (rd_ff[65:64])
         KIND_RECT: hit = (y >= py) && (y < py + b);
         KIND_LINE: hit = (y == py);
         KIND_TRI: begin
            hit = (d >= 0) && (d < a);
            hi  = px + d + 18'sd1;
         end
         default: hit = 1'b0;
      endcase
      span = '0;
      for (int x = 0; x < 64; x++) begin
         if (x < CANVAS_COLS && hit && 18'(x) >= lo && 18'(x) < hi)
            span[x] = 1'b1;
      end
      dy20 = 24'(d) * 24'sd20;
      r20  = 24'(a) * 24'sd20;
      lim  = 48'(r20) * 48'(r20) - 48'(dy20) * 48'(dy20);
      circ = '0;
      for (int x = 0; x < 64; x++) begin
         dx11 = 25'(18'(x) - px) * 25'sd11;
         dx2  = 50'(dx11) * 50'(dx11);
         if (x < CANVAS_COLS && dx2 <= 50'(lim)) circ[x] = 1'b1;
      end
   end

   logic [63:0] shape_mask;
   assign shape_mask = (rd_ff[65:64] == KIND_CIRCLE) ? circ : span;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      active_in = active_ff;
      walk_in   = walk_ff;
      row_in    = row_ff;
      acc_in    = acc_ff;
      rvalid_in = rvalid_ff && !rsp_pop;
      rsp_in    = rsp_ff;
      line_ok_in = line_ok_ff;
      cmd_take  = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = count_ff[SW-1:0];
      mem_ra    = walk_ff[SW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rvalid_in) begin
               cmd_take = 1'b1;
               rsp_in   = '0;
               case (cmd.mode)
                  MODE_ADD: begin
                     if (count_ff >= CW'(SHAPE_SLOTS)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        mem_we = 1'b1;
                        active_in[count_ff[SW-1:0]] = 1'b1;
                        count_in = count_ff + 1'b1;
                        rsp_in.added_id = 7'(count_ff + 1'b1);
                     end
                     rvalid_in = 1'b1;
                  end
                  MODE_DELETE: begin
                     if (cmd.target_id == 16'd0 || cmd.target_id > 16'(count_ff))
                        rsp_in.status = STATUS_BAD_ID;
                     else
                        active_in[SW'(cmd.target_id - 16'd1)] = 1'b0;
                     rvalid_in = 1'b1;
                  end
                  MODE_RENDER: begin
                     if (32'(cmd.row_index) >= CANVAS_ROWS || count_ff == '0) begin
                        rvalid_in = 1'b1;
                     end else begin
                        row_in   = cmd.row_index;
                        walk_in  = '0;
                        acc_in   = '0;
                        mem_ra   = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: rvalid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            line_ok_in = active_ff[walk_ff[SW-1:0]];
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            if (line_ok_ff) acc_in = acc_ff | shape_mask;
            walk_in = walk_ff + 1'b1;
            mem_ra  = walk_in[SW-1:0];
            if (walk_in == count_ff) begin
               rsp_in    = '0;
               rsp_in.row_bits = acc_in;
               rvalid_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         active_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         active_ff <= active_in;
         rvalid_ff <= rvalid_in;
      end
      walk_ff    <= walk_in;
      row_ff     <= row_in;
      acc_ff     <= acc_in;
      rsp_ff     <= rsp_in;
      line_ok_ff <= line_ok_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/core/shape_list_row_rasterizer_unit.sv
// Top level of the shape list row rasterizer.
// Keeps a display list of up to SHAPE_SLOTS shapes and renders one canvas row
// per render transaction. With the back end free, an add, delete or unused-mode
// transaction has its result registered at the edge that accepts it. A render
// walks every slot up to the count of added shapes, deleted ones included: each
// slot is read from the single read port of the shape memory in ST_READ and its
// row mask is formed in ST_SHAPE. A render of an empty list or of a row at or
// beyond CANVAS_ROWS gives an all-zero row without a walk. Requests enter a
// two-entry queue, so the front keeps accepting while the back works. The result
// is held in an output register until popped, and the back takes its next command
// only in a cycle where no result is waiting or the waiting one is being popped.
`default_nettype none
module shape_list_row_rasterizer_unit #(
   parameter int CANVAS_ROWS = slrr_pkg::DEF_CANVAS_ROWS,
   parameter int CANVAS_COLS = slrr_pkg::DEF_CANVAS_COLS,
   parameter int SHAPE_SLOTS = slrr_pkg::DEF_SHAPE_SLOTS
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   output logic         full,
   input  wire  [1:0]   req_mode,
   input  wire  [1:0]   req_shape_kind,
   input  wire  [15:0]  req_pos_x,
   input  wire  [15:0]  req_pos_y,
   input  wire  [15:0]  req_size_a,
   input  wire  [15:0]  req_size_b,
   input  wire  [15:0]  req_target_id,
   input  wire  [4:0]   req_row_index,
   output logic         empty,
   input  wire          pop,
   output logic [6:0]   rsp_added_id,
   output logic [63:0]  rsp_row_bits,
   output logic [1:0]   rsp_status
);
   import slrr_pkg::*;

   cmd_type cmd_in, cmd_q;
   rsp_type rsp;
   logic    cmd_valid, cmd_take, rsp_valid;

   // Pack the request transaction.
   assign cmd_in = '{mode: req_mode, kind: req_shape_kind, pos_x: req_pos_x,
                     pos_y: req_pos_y, size_a: req_size_a, size_b: req_size_b,
                     target_id: req_target_id, row_index: req_row_index};

   slrr_front u_front (
      .clock, .reset, .push, .full, .cmd_in,
      .cmd_valid, .cmd_out(cmd_q), .cmd_take
   );

   slrr_back #(
      .CANVAS_ROWS(CANVAS_ROWS), .CANVAS_COLS(CANVAS_COLS), .SHAPE_SLOTS(SHAPE_SLOTS)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd(cmd_q), .cmd_take,
      .rsp_valid, .rsp, .rsp_pop(pop)
   );

   assign empty        = !rsp_valid;
   assign rsp_added_id = rsp.added_id;
   assign rsp_row_bits = rsp.row_bits;
   assign rsp_status   = rsp.status;
endmodule
`default_nettype wire
